@@ sv/sts_pkg.sv @@
package sts_pkg;

  localparam int LINE_WIDTH = 24;
  localparam int LENGTH_WIDTH = 12;

  localparam logic [LINE_WIDTH-1:0] LINE_SAT = {LINE_WIDTH{1'b1}};
  localparam logic [LENGTH_WIDTH-1:0] LEN_SAT = {LENGTH_WIDTH{1'b1}};
  localparam logic [LINE_WIDTH-1:0] LINE_ONE = {{(LINE_WIDTH-1){1'b0}}, 1'b1};
  localparam logic [LENGTH_WIDTH-1:0] LEN_ONE = {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};

  localparam logic [5:0] K_END     = 6'd0;
  localparam logic [5:0] K_INVALID = 6'd1;
  localparam logic [5:0] K_IDENT   = 6'd2;
  localparam logic [5:0] K_NUMBER  = 6'd3;
  localparam logic [5:0] K_LITERAL = 6'd4;
  localparam logic [5:0] K_SPECIAL = 6'd5;
  localparam logic [5:0] K_DIV     = 6'd18;
  localparam logic [5:0] K_DIVEQ   = 6'd44;

  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_NOCLOSE = 3'd1;
  localparam logic [2:0] E_NOOPEN  = 3'd2;
  localparam logic [2:0] E_ESCAPE  = 3'd3;
  localparam logic [2:0] E_NEWLINE = 3'd4;
  localparam logic [2:0] E_UNICODE = 3'd5;
  localparam logic [2:0] E_BADCHAR = 3'd6;

  typedef enum logic [18:0] {
    M_IDLE        = 19'd1 << 0,
    M_SLASH       = 19'd1 << 1,
    M_BLOCK       = 19'd1 << 2,
    M_BLOCK_STAR  = 19'd1 << 3,
    M_LINE        = 19'd1 << 4,
    M_OP          = 19'd1 << 5,
    M_DOLLAR      = 19'd1 << 6,
    M_SPECIAL     = 19'd1 << 7,
    M_IDENT       = 19'd1 << 8,
    M_NUM_INT     = 19'd1 << 9,
    M_NUM_DOT     = 19'd1 << 10,
    M_NUM_NAN     = 19'd1 << 11,
    M_NUM_EXP     = 19'd1 << 12,
    M_NUM_EXP_DIG = 19'd1 << 13,
    M_LIT_BODY    = 19'd1 << 14,
    M_LIT_ESC     = 19'd1 << 15,
    M_LIT_HEX     = 19'd1 << 16,
    M_LIT_SKIP    = 19'd1 << 17,
    M_LIT_AFTER   = 19'd1 << 18
  } mode_t;

  // character classes worked out in the front part
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       digit;
    logic       alpha;
    logic       blank;
    logic       quote;
    logic       pair;
    logic [5:0] single;
    logic       suffix;
  } cls_t;

  typedef struct packed {
    logic [5:0]              kind;
    logic [2:0]              err;
    logic [LINE_WIDTH-1:0]   line;
    logic [LENGTH_WIDTH-1:0] len;
  } tok_t;

  function automatic logic [5:0] single_code(input logic [7:0] c);
    case (c)
      ";": single_code = 6'd6;
      ":": single_code = 6'd7;
      ",": single_code = 6'd8;
      "(": single_code = 6'd9;
      ")": single_code = 6'd10;
      "{": single_code = 6'd11;
      "}": single_code = 6'd12;
      "[": single_code = 6'd13;
      "]": single_code = 6'd14;
      "+": single_code = 6'd15;
      "-": single_code = 6'd16;
      "*": single_code = 6'd17;
      "/": single_code = 6'd18;
      "^": single_code = 6'd19;
      ".": single_code = 6'd20;
      "?": single_code = 6'd21;
      "#": single_code = 6'd22;
      "~": single_code = 6'd23;
      "%": single_code = 6'd24;
      "@": single_code = 6'd25;
      "&": single_code = 6'd28;
      "|": single_code = 6'd29;
      "!": single_code = 6'd30;
      "=": single_code = 6'd31;
      "<": single_code = 6'd35;
      ">": single_code = 6'd36;
      default: single_code = 6'd0;
    endcase
  endfunction

  function automatic logic [5:0] pair_code(input logic [7:0] a, input logic [7:0] b);
    pair_code = 6'd0;
    case (a)
      "+": pair_code = (b == "=") ? 6'd41 : (b == "+") ? 6'd33 : 6'd0;
      "-": pair_code = (b == "=") ? 6'd42 : (b == "@") ? 6'd45 :
                       (b == "-") ? 6'd34 : (b == ">") ? 6'd32 : 6'd0;
      "*": pair_code = (b == "=") ? 6'd43 : (b == "*") ? 6'd19 : 6'd0;
      "?": pair_code = (b == "@") ? 6'd46 : 6'd0;
      "&": pair_code = (b == "&") ? 6'd26 : 6'd0;
      "|": pair_code = (b == "|") ? 6'd27 : 6'd0;
      "!": pair_code = (b == "=") ? 6'd38 : 6'd0;
      "=": pair_code = (b == "=") ? 6'd37 : 6'd0;
      "<": pair_code = (b == "=") ? 6'd39 : 6'd0;
      ">": pair_code = (b == "=") ? 6'd40 : 6'd0;
      default: pair_code = 6'd0;
    endcase
  endfunction

endpackage

@@ sv/script_token_scanner_core.sv @@
// A token record is offered from the result buffer once the item that completes it
// has passed the queue and the scan state machine.
// Throughput: one item per cycle while m_axis_tready is high and a step gives at most
// one record; a step that gives two records holds the back part until the first leaves.
// A two-entry queue parts the character classifier from the scan state machine.
// Reset (rst, synchronous): scanner idle, line count 1, unicode escapes enabled.
module script_token_scanner_core import sts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // ch
  input  logic        s_axis_tuser,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // token_kind, error_code, line_number, token_length
  output logic        m_axis_tlast
);

  logic uni_en;
  logic q_valid, q_ready;
  cls_t q_data;
  tok_t tok;

  always_ff @(posedge clk) begin
    if (rst) uni_en <= 1'b1;
    else if (cfg_we) uni_en <= cfg_wdata;
  end

  sts_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .ch(s_axis_tdata), .eoi(s_axis_tuser),
    .q_valid, .q_ready, .q_data
  );

  sts_back u_back (
    .clk, .rst, .uni_en,
    .q_valid, .q_ready, .q_data,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_tok(tok), .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, tok.len, tok.line, tok.err, tok.kind};

endmodule

@@ sv/sts_front.sv @@
module sts_front import sts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       eoi,
  output logic       q_valid,
  input  logic       q_ready,
  output cls_t       q_data
);

  logic [1:0] cnt;
  logic       rd, wr;
  cls_t       slot [2];
  logic       wp, rp;
  cls_t       c;

  always_comb begin
    c.ch     = ch;
    c.eoi    = eoi;
    c.digit  = ch >= "0" && ch <= "9";
    c.alpha  = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
    c.blank  = ch == " " || ch == 8'h09 || ch == 8'h0d || ch == 8'h0a;
    c.quote  = ch == 8'h22 || ch == 8'h27;
    c.pair   = ch == "+" || ch == "-" || ch == "*" || ch == "?" || ch == "&" ||
               ch == "|" || ch == "!" || ch == "=" || ch == "<" || ch == ">";
    c.single = single_code(ch);
    c.suffix = ch == "T" || ch == "G" || ch == "k" || ch == "m" || ch == "M" ||
               ch == "u" || ch == "n" || ch == "p" || ch == "f" || ch == "a";
  end

  assign in_ready = cnt != 2'd2;
  assign q_valid  = cnt != 2'd0;
  assign q_data   = slot[rp];
  assign wr = in_valid && in_ready;
  assign rd = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (wr) slot[wp] <= c;
    if (rst) begin
      cnt <= 2'd0;
      wp <= 1'b0;
      rp <= 1'b0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

@@ sv/sts_back.sv @@
module sts_back import sts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        uni_en,
  input  logic        q_valid,
  output logic        q_ready,
  input  cls_t        q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output tok_t        out_tok,
  output logic        out_last
);

  mode_t                   mode, mode_next;
  logic [LINE_WIDTH-1:0]   line, line_next;
  logic [LENGTH_WIDTH-1:0] len, len_next;
  logic [LENGTH_WIDTH-1:0] gap, gap_next;
  logic                    cq, cq_next;
  logic [2:0]              hexc, hexc_next;
  logic [2:0]              perr, perr_next;
  logic [7:0]              opf, opf_next;

  // two-entry result buffer
  tok_t   rbuf [2];
  logic   rlast [2];
  logic   rn;
  logic   rcnt;

  tok_t   t0, t1;
  logic   e0, e1;
  logic   fire;
  logic [7:0] ch;
  logic   word, again;
  logic [LINE_WIDTH-1:0] line_pre;
  logic [LENGTH_WIDTH+1:0] sum;

  assign ch = q_data.ch;
  assign word = q_data.alpha || q_data.digit || ch == "_";
  // take a new item once the last waiting result leaves
  assign q_ready = !out_valid || (out_ready && !rn);
  assign fire = q_valid && q_ready;

  function automatic logic [LINE_WIDTH-1:0] linc(input logic [LINE_WIDTH-1:0] l);
    linc = (l == LINE_SAT) ? l : l + LINE_ONE;
  endfunction

  function automatic logic [LENGTH_WIDTH-1:0] ninc(input logic [LENGTH_WIDTH-1:0] l);
    ninc = (l == LEN_SAT) ? l : l + LEN_ONE;
  endfunction

  always_comb begin
    mode_next = mode;
    line_next = line;
    len_next  = len;
    gap_next  = gap;
    cq_next   = cq;
    hexc_next = hexc;
    perr_next = perr;
    opf_next  = opf;
    e0 = 1'b0;
    e1 = 1'b0;
    t0 = '0;
    t1 = '0;
    again = 1'b0;
    line_pre = line;
    sum = '0;
    if (q_data.eoi) begin
      e0 = 1'b1;
      t0.line = line;
      t0.len = len;
      case (mode)
        M_SLASH: t0.kind = K_DIV;
        M_OP: t0.kind = single_code(opf);
        M_DOLLAR: begin t0.kind = K_INVALID; t0.err = E_NOOPEN; end
        M_SPECIAL: begin t0.kind = K_INVALID; t0.err = E_NOCLOSE; end
        M_IDENT: t0.kind = K_IDENT;
        M_NUM_INT, M_NUM_DOT, M_NUM_NAN, M_NUM_EXP, M_NUM_EXP_DIG: t0.kind = K_NUMBER;
        M_LIT_BODY, M_LIT_ESC, M_LIT_HEX, M_LIT_AFTER: t0.kind = K_LITERAL;
        M_LIT_SKIP: begin t0.kind = K_INVALID; t0.err = perr; end
        default: e0 = 1'b0;
      endcase
      e1 = 1'b1;
      t1.kind = K_END;
      t1.line = line;
      mode_next = M_IDLE;
      line_next = {{(LINE_WIDTH-1){1'b0}}, 1'b1};
      len_next = '0;
      gap_next = '0;
      cq_next = 1'b0;
      hexc_next = '0;
      perr_next = '0;
      opf_next = '0;
    end else begin
      t0.line = line;
      case (mode)
        M_SLASH: begin
          if (ch == "*") mode_next = M_BLOCK;
          else if (ch == "/") mode_next = M_LINE;
          else if (ch == "=") begin
            e0 = 1'b1; t0.kind = K_DIVEQ; t0.len = ninc(len);
          end else begin
            e0 = 1'b1; t0.kind = K_DIV; t0.len = len; again = 1'b1;
          end
        end
        M_BLOCK: begin
          if (ch == "*") mode_next = M_BLOCK_STAR;
          else if (ch == 8'h0a) line_next = linc(line);
        end
        M_BLOCK_STAR: begin
          if (ch == "/") begin mode_next = M_IDLE; len_next = '0; end
          else if (ch != "*") begin
            if (ch == 8'h0a) line_next = linc(line);
            mode_next = M_BLOCK;
          end
        end
        M_LINE: begin
          if (ch == 8'h0a) begin
            line_next = linc(line); mode_next = M_IDLE; len_next = '0;
          end
        end
        M_OP: begin
          if (pair_code(opf, ch) != 6'd0) begin
            e0 = 1'b1; t0.kind = pair_code(opf, ch); t0.len = ninc(len);
          end else begin
            e0 = 1'b1; t0.kind = single_code(opf); t0.len = len; again = 1'b1;
          end
        end
        M_DOLLAR: begin
          if (ch == "{") begin len_next = ninc(len); mode_next = M_SPECIAL; end
          else begin
            e0 = 1'b1; t0.kind = K_INVALID; t0.err = E_NOOPEN; t0.len = len;
            again = 1'b1;
          end
        end
        M_SPECIAL: begin
          if (word || ch == "." || ch == "*" || ch == "-" || ch == "%")
            len_next = ninc(len);
          else if (ch == "}") begin
            e0 = 1'b1; t0.kind = K_SPECIAL; t0.len = ninc(len);
          end else begin
            e0 = 1'b1; t0.kind = K_INVALID; t0.err = E_NOCLOSE; t0.len = len;
            again = 1'b1;
          end
        end
        M_IDENT: begin
          if (word) len_next = ninc(len);
          else begin e0 = 1'b1; t0.kind = K_IDENT; t0.len = len; again = 1'b1; end
        end
        M_NUM_INT, M_NUM_DOT: begin
          if (mode == M_NUM_DOT && ch == "#") begin
            len_next = ninc(len); mode_next = M_NUM_NAN;
          end else begin
            mode_next = M_NUM_INT;
            if (q_data.digit) len_next = ninc(len);
            else if (ch == ".") begin len_next = ninc(len); mode_next = M_NUM_DOT; end
            else if (ch == "e" || ch == "E") begin
              len_next = ninc(len); mode_next = M_NUM_EXP;
            end else if (q_data.suffix) begin
              e0 = 1'b1; t0.kind = K_NUMBER; t0.len = ninc(len);
            end else begin
              e0 = 1'b1; t0.kind = K_NUMBER; t0.len = len; again = 1'b1;
            end
          end
        end
        M_NUM_NAN: begin
          if (q_data.alpha) len_next = ninc(len);
          else begin e0 = 1'b1; t0.kind = K_NUMBER; t0.len = len; again = 1'b1; end
        end
        M_NUM_EXP: begin
          if (ch == "+" || ch == "-" || q_data.digit) begin
            len_next = ninc(len); mode_next = M_NUM_EXP_DIG;
          end else begin
            e0 = 1'b1; t0.kind = K_NUMBER; t0.len = len; again = 1'b1;
          end
        end
        M_NUM_EXP_DIG: begin
          if (q_data.digit) len_next = ninc(len);
          else begin e0 = 1'b1; t0.kind = K_NUMBER; t0.len = len; again = 1'b1; end
        end
        M_LIT_BODY: begin
          len_next = ninc(len);
          if (ch == (cq ? 8'h27 : 8'h22)) begin mode_next = M_LIT_AFTER; gap_next = '0; end
          else if (ch == 8'h5c) mode_next = M_LIT_ESC;
          else if (ch == 8'h0a) begin
            line_next = linc(line); perr_next = E_NEWLINE; mode_next = M_LIT_SKIP;
          end
        end
        M_LIT_ESC: begin
          len_next = ninc(len);
          if (q_data.quote || ch == "n" || ch == "r" || ch == "t" || ch == 8'h5c ||
              ch == "/") mode_next = M_LIT_BODY;
          else if (ch == "u") begin
            if (uni_en) begin hexc_next = '0; mode_next = M_LIT_HEX; end
            else begin perr_next = E_UNICODE; mode_next = M_LIT_SKIP; end
          end else begin
            if (ch == 8'h0a) line_next = linc(line);
            perr_next = E_ESCAPE; mode_next = M_LIT_SKIP;
          end
        end
        M_LIT_HEX: begin
          len_next = ninc(len);
          if (ch == 8'h0a) line_next = linc(line);
          hexc_next = hexc + 3'd1;
          if (hexc == 3'd3) begin hexc_next = '0; mode_next = M_LIT_BODY; end
        end
        M_LIT_SKIP: begin
          if (ch == (cq ? 8'h27 : 8'h22)) begin
            e0 = 1'b1; t0.kind = K_INVALID; t0.err = perr; t0.len = ninc(len);
            perr_next = '0;
          end else begin
            len_next = ninc(len);
            if (ch == 8'h0a) line_next = linc(line);
          end
        end
        M_LIT_AFTER: begin
          if (q_data.blank) begin
            if (ch == 8'h0a) line_next = linc(line);
            gap_next = ninc(gap);
          end else if (q_data.quote) begin
            sum = {2'b00, len} + {2'b00, gap} + {2'b00, LEN_ONE};
            len_next = (sum > {2'b00, LEN_SAT}) ? LEN_SAT : sum[LENGTH_WIDTH-1:0];
            gap_next = '0;
            cq_next = ch == 8'h27;
            mode_next = M_LIT_BODY;
          end else begin
            e0 = 1'b1; t0.kind = K_LITERAL; t0.len = len; again = 1'b1;
          end
        end
        default: again = 1'b1;
      endcase
      if (e0) begin
        mode_next = M_IDLE;
        len_next = '0;
      end
      if (again) begin
        line_pre = line_next;
        mode_next = M_IDLE;
        len_next = '0;
        t1.line = line_pre;
        t1.len = LEN_ONE;
        if (q_data.blank) begin
          if (ch == 8'h0a) line_next = linc(line_pre);
        end else if (ch == "/") begin mode_next = M_SLASH; len_next = LEN_ONE; end
        else if (q_data.pair) begin opf_next = ch; mode_next = M_OP; len_next = LEN_ONE; end
        else if (q_data.single != 6'd0) begin e1 = 1'b1; t1.kind = q_data.single; end
        else if (ch == "$") begin mode_next = M_DOLLAR; len_next = LEN_ONE; end
        else if (q_data.alpha || ch == "_") begin mode_next = M_IDENT; len_next = LEN_ONE; end
        else if (q_data.digit) begin mode_next = M_NUM_INT; len_next = LEN_ONE; end
        else if (q_data.quote) begin
          cq_next = ch == 8'h27; perr_next = '0; mode_next = M_LIT_BODY; len_next = LEN_ONE;
        end else begin
          e1 = 1'b1; t1.kind = K_INVALID; t1.err = E_BADCHAR;
        end
      end
    end
  end

  // results leave from rbuf[0] then rbuf[1]
  assign out_valid = rn || rcnt;
  assign out_tok  = rn ? rbuf[0] : rbuf[1];
  assign out_last = rn ? rlast[0] : rlast[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      line <= {{(LINE_WIDTH-1){1'b0}}, 1'b1};
      len  <= '0;
      gap  <= '0;
      cq   <= 1'b0;
      hexc <= '0;
      perr <= '0;
      opf  <= '0;
      rn   <= 1'b0;
      rcnt <= 1'b0;
    end else begin
      if (fire) begin
        mode <= mode_next;
        line <= line_next;
        len  <= len_next;
        gap  <= gap_next;
        cq   <= cq_next;
        hexc <= hexc_next;
        perr <= perr_next;
        opf  <= opf_next;
        rn   <= e0 && e1;
        rcnt <= e0 || e1;
        rbuf[0] <= t0;
        rlast[0] <= 1'b0;
        rbuf[1] <= e1 ? t1 : t0;
        rlast[1] <= 1'b1;
      end else if (out_valid && out_ready) begin
        if (rn) rn <= 1'b0;
        else rcnt <= 1'b0;
      end
    end
  end

endmodule
